// ----- rtl/salru_pkg.sv -----
// Shared constants and types for the set-associative LRU tag lookup.
// No dependencies; every other file refers to it by scoped names.
package salru_pkg;

    localparam int ADDR_W     = 32;
    localparam int CNT_W      = 32;
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int OFFSET_MIN = 2;
    localparam int OFFSET_MAX = 12;
    localparam int INDEX_MAX  = 12;
    localparam int IDX_MAX_W  = INDEX_MAX;
    localparam int TAG_W      = ADDR_W - OFFSET_MIN;
    localparam int SHIFT_W    = 5;

    // Reciprocal shift that makes the quotient exact for every IDX_MAX_W-bit index
    localparam int QUOT_SHIFT = 2 * IDX_MAX_W;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

    localparam logic [CFG_W-1:0] OFFSET_RESET = 4'd2;
    localparam logic [CFG_W-1:0] INDEX_RESET  = 4'd8;
    localparam logic [CFG_W-1:0] WAYS_RESET   = 4'd1;

    // Geometry after range limiting
    typedef struct packed {
        logic [CFG_W-1:0] offset_bits;
        logic [CFG_W-1:0] index_bits;
        logic [CFG_W-1:0] ways_in_use;
    } cfg_t;

    // Back end status seen by the front end
    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

// ----- rtl/salru_front.sv -----
// Front end: accepts fetch addresses, splits them into set and tag, pushes to the queue.
// Depends on salru_pkg.
module salru_front #(
    parameter int MAX_SETS = 256,
    parameter int SET_W    = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [salru_pkg::ADDR_W-1:0]        access_address,
    input  salru_pkg::cfg_t                     cfg,
    input  salru_pkg::back_status_t             back_status,
    input  logic [salru_pkg::QCNT_W-1:0]        q_count,
    output logic                                busy,
    output logic                                push,
    output logic [salru_pkg::TAG_W-1:0]         push_tag,
    output logic [SET_W-1:0]                    push_set
);

    localparam int IW    = salru_pkg::IDX_MAX_W;
    localparam int QS    = salru_pkg::QUOT_SHIFT;
    localparam int PW    = IW + QS + 1;
    localparam longint RECIP_VAL =
        ((longint'(1) << QS) + longint'(MAX_SETS) - 1) / longint'(MAX_SETS);
    localparam logic [QS:0] RECIP   = (QS + 1)'(RECIP_VAL);
    localparam logic [IW:0] SETS_C  = (IW + 1)'(MAX_SETS);

    logic                          s1_valid_reg, s1_valid_next;
    logic [IW-1:0]                 s1_idx_reg;
    logic [salru_pkg::TAG_W-1:0]   s1_tag_reg;
    logic                          s2_valid_reg, s2_valid_next;
    logic [IW-1:0]                 s2_idx_reg;
    logic [IW-1:0]                 s2_quot_reg;
    logic [salru_pkg::TAG_W-1:0]   s2_tag_reg;

    logic                          accept;
    logic [salru_pkg::ADDR_W-1:0]  shifted;
    logic [salru_pkg::ADDR_W-1:0]  tag_full;
    logic [salru_pkg::SHIFT_W-1:0] tag_shift;
    logic [IW-1:0]                 idx_mask;
    logic [IW-1:0]                 idx;
    logic [PW-1:0]                 quot_prod;
    logic [2*IW:0]                 set_prod;
    logic [IW-1:0]                 set_rem;
    logic [salru_pkg::QCNT_W:0]    in_flight;

    // Hold off during the clear and while the queue could not absorb everything in flight
    assign in_flight = {1'b0, q_count} + (salru_pkg::QCNT_W + 1)'(s1_valid_reg)
                     + (salru_pkg::QCNT_W + 1)'(s2_valid_reg);
    assign busy   = back_status.clearing
                 || (in_flight >= (salru_pkg::QCNT_W + 1)'(salru_pkg::QDEPTH));
    assign accept = start && !busy;

    assign shifted   = access_address >> cfg.offset_bits;
    assign idx_mask  = ~({IW{1'b1}} << cfg.index_bits);
    assign idx       = shifted[IW-1:0] & idx_mask;
    assign tag_shift = salru_pkg::SHIFT_W'(cfg.offset_bits)
                     + salru_pkg::SHIFT_W'(cfg.index_bits);
    assign tag_full  = access_address >> tag_shift;

    // Index modulo set count: quotient by reciprocal, then subtract
    assign quot_prod = PW'(s1_idx_reg) * PW'(RECIP);
    assign set_prod  = (2*IW + 1)'(s2_quot_reg) * (2*IW + 1)'(SETS_C);
    assign set_rem   = s2_idx_reg - set_prod[IW-1:0];

    assign s1_valid_next = accept;
    assign s2_valid_next = s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg <= idx;
            s1_tag_reg <= tag_full[salru_pkg::TAG_W-1:0];
        end
        if (s1_valid_reg)
        begin
            s2_idx_reg  <= s1_idx_reg;
            s2_quot_reg <= quot_prod[QS +: IW];
            s2_tag_reg  <= s1_tag_reg;
        end
    end

    assign push     = s2_valid_reg;
    assign push_tag = s2_tag_reg;
    assign push_set = set_rem[SET_W-1:0];

endmodule

// ----- rtl/salru_queue.sv -----
// Short request queue between the front end and the back end.
// Depends on salru_pkg.
module salru_queue #(
    parameter int SET_W = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic [salru_pkg::TAG_W-1:0]         push_tag,
    input  logic [SET_W-1:0]                    push_set,
    input  logic                                pop,
    output logic                                empty,
    output logic [salru_pkg::QCNT_W-1:0]        count,
    output logic [salru_pkg::TAG_W-1:0]         head_tag,
    output logic [SET_W-1:0]                    head_set
);

    logic [salru_pkg::TAG_W-1:0]  tag_q [salru_pkg::QDEPTH];
    logic [SET_W-1:0]             set_q [salru_pkg::QDEPTH];
    logic [salru_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [salru_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [salru_pkg::QCNT_W-1:0] count_reg, count_next;

    assign wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            tag_q[wr_ptr_reg] <= push_tag;
            set_q[wr_ptr_reg] <= push_set;
        end
    end

    assign empty    = (count_reg == '0);
    assign count    = count_reg;
    assign head_tag = tag_q[rd_ptr_reg];
    assign head_set = set_q[rd_ptr_reg];

endmodule

// ----- rtl/salru_back.sv -----
// Back end: tag and recency stores, lookup, LRU update, counters and result strobe.
// Depends on salru_pkg.
module salru_back #(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 8,
    parameter int SET_W    = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  salru_pkg::cfg_t                     cfg,
    input  logic                                q_empty,
    input  logic [salru_pkg::TAG_W-1:0]         q_tag,
    input  logic [SET_W-1:0]                    q_set,
    output logic                                pop,
    output salru_pkg::back_status_t             back_status,
    output logic                                done,
    output logic                                hit,
    output logic [salru_pkg::CNT_W-1:0]         access_total,
    output logic [salru_pkg::CNT_W-1:0]         miss_total
);

    localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W  = RANK_W;
    localparam int OLD_W  = RANK_W + 1;
    localparam int TW     = salru_pkg::TAG_W;

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    typedef struct packed {
        logic [MAX_WAYS-1:0]             valid;
        logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    } meta_t;

    typedef logic [MAX_WAYS-1:0][TW-1:0] tag_row_t;

    tag_row_t tag_mem  [MAX_SETS];
    meta_t    meta_mem [MAX_SETS];

    logic [1:0]                 state_reg, state_next;
    logic [SET_W-1:0]           clear_ptr_reg, clear_ptr_next;
    logic [SET_W-1:0]           cur_set_reg;
    logic [TW-1:0]              cur_tag_reg;
    tag_row_t                   tag_row_reg;
    meta_t                      meta_row_reg;
    logic                       done_reg, done_next;
    logic                       hit_reg;
    logic [salru_pkg::CNT_W-1:0] access_cnt_reg, access_cnt_next;
    logic [salru_pkg::CNT_W-1:0] miss_cnt_reg, miss_cnt_next;

    logic                       clearing;
    logic                       update;
    logic [MAX_WAYS-1:0]        in_use;
    logic                       hit_any;
    logic [WAY_W-1:0]           hit_way;
    logic                       free_any;
    logic [WAY_W-1:0]           free_way;
    logic [RANK_W-1:0]          max_rank;
    logic [WAY_W-1:0]           max_way;
    logic [WAY_W-1:0]           target;
    logic [OLD_W-1:0]           old_rank;
    meta_t                      meta_new;
    tag_row_t                   tag_row_new;
    logic                       meta_we;
    logic [SET_W-1:0]           meta_waddr;
    meta_t                      meta_wdata;

    assign clearing = (state_reg == ST_CLEAR);
    assign update   = (state_reg == ST_UPDATE);
    assign pop      = (state_reg == ST_IDLE) && !q_empty;
    assign back_status.clearing = clearing;

    always_comb
    begin
        state_next     = state_reg;
        clear_ptr_next = clear_ptr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clear_ptr_next = clear_ptr_reg + 1'b1;
                if (clear_ptr_reg == SET_W'(MAX_SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            in_use[w] = (w < int'(cfg.ways_in_use));
        end
    end

    // Lookup and replacement choice; lowest way wins every tie
    always_comb
    begin
        hit_any  = 1'b0;
        hit_way  = '0;
        free_any = 1'b0;
        free_way = '0;
        max_rank = '0;
        max_way  = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (in_use[w] && meta_row_reg.valid[w] && (tag_row_reg[w] == cur_tag_reg)
                && !hit_any)
            begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (in_use[w] && !meta_row_reg.valid[w] && !free_any)
            begin
                free_any = 1'b1;
                free_way = WAY_W'(w);
            end
            if (in_use[w] && (meta_row_reg.rank[w] > max_rank))
            begin
                max_rank = meta_row_reg.rank[w];
                max_way  = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        priority if (hit_any)
        begin
            target   = hit_way;
            old_rank = {1'b0, meta_row_reg.rank[hit_way]};
        end
        else if (free_any)
        begin
            target   = free_way;
            old_rank = OLD_W'(MAX_WAYS);
        end
        else
        begin
            target   = max_way;
            old_rank = {1'b0, max_rank};
        end
    end

    // Age every more recent way by one, then make the target most recent
    always_comb
    begin
        meta_new    = meta_row_reg;
        tag_row_new = tag_row_reg;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (in_use[w] && (WAY_W'(w) != target) && meta_row_reg.valid[w]
                && ({1'b0, meta_row_reg.rank[w]} < old_rank)
                && (meta_row_reg.rank[w] != RANK_W'(MAX_WAYS - 1)))
            begin
                meta_new.rank[w] = meta_row_reg.rank[w] + 1'b1;
            end
        end
        meta_new.valid[target] = 1'b1;
        meta_new.rank[target]  = '0;
        tag_row_new[target]    = cur_tag_reg;
    end

    assign meta_we    = clearing || update;
    assign meta_waddr = clearing ? clear_ptr_reg : cur_set_reg;
    assign meta_wdata = clearing ? meta_t'('0) : meta_new;

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        if (update && !hit_any)
        begin
            tag_mem[cur_set_reg] <= tag_row_new;
        end
        if (pop)
        begin
            tag_row_reg  <= tag_mem[q_set];
            meta_row_reg <= meta_mem[q_set];
            cur_set_reg  <= q_set;
            cur_tag_reg  <= q_tag;
        end
        if (update)
        begin
            hit_reg <= hit_any;
        end
    end

    assign done_next = update;

    // Saturate both counters at all ones
    always_comb
    begin
        access_cnt_next = access_cnt_reg;
        miss_cnt_next   = miss_cnt_reg;
        if (update)
        begin
            if (access_cnt_reg != '1)
            begin
                access_cnt_next = access_cnt_reg + 1'b1;
            end
            if (!hit_any && (miss_cnt_reg != '1))
            begin
                miss_cnt_next = miss_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_ptr_reg  <= '0;
            done_reg       <= 1'b0;
            access_cnt_reg <= '0;
            miss_cnt_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_ptr_reg  <= clear_ptr_next;
            done_reg       <= done_next;
            access_cnt_reg <= access_cnt_next;
            miss_cnt_reg   <= miss_cnt_next;
        end
    end

    assign done         = done_reg;
    assign hit          = hit_reg;
    assign access_total = access_cnt_reg;
    assign miss_total   = miss_cnt_reg;

endmodule

// ----- rtl/set_assoc_lru_cache_lookup_top.sv -----
// Top level of the set-associative LRU tag lookup: configuration registers and wiring.
// Depends on salru_pkg, salru_front, salru_queue and salru_back.
//
//   channel   handshake            payload
//   request   start / busy         access_address
//   result    done (one cycle)     hit, access_total, miss_total
//   config    cfg_write            cfg_index, cfg_data
//
// In the back end a request reads the set's tag and recency rows as it is popped in
// the idle state, then writes the recency row back, and the tag row on a miss, in the
// update state. Ahead of that it passes the two front stages and the queue, and the
// result strobe done is registered from the update state. The back end pops no new
// request until that write is done. After reset, busy stays high while the recency
// store is cleared one set per cycle. Results cannot be stalled; after the clear, busy
// rises only while the queue and the two front stages together hold four requests.
module set_assoc_lru_cache_lookup_top #(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [salru_pkg::ADDR_W-1:0]        access_address,
    output logic                                done,
    output logic                                hit,
    output logic [salru_pkg::CNT_W-1:0]         access_total,
    output logic [salru_pkg::CNT_W-1:0]         miss_total,
    input  logic                                cfg_write,
    input  logic [salru_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [salru_pkg::CFG_W-1:0]         cfg_data
);

    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int CW    = salru_pkg::CFG_W;

    logic [CW-1:0]                 offset_bits_reg, offset_bits_next;
    logic [CW-1:0]                 index_bits_reg, index_bits_next;
    logic [CW-1:0]                 ways_reg, ways_next;
    salru_pkg::cfg_t               cfg;
    salru_pkg::back_status_t       back_status;

    logic                          push;
    logic [salru_pkg::TAG_W-1:0]   push_tag;
    logic [SET_W-1:0]              push_set;
    logic                          pop;
    logic                          q_empty;
    logic [salru_pkg::QCNT_W-1:0]  q_count;
    logic [salru_pkg::TAG_W-1:0]   head_tag;
    logic [SET_W-1:0]              head_set;

    always_comb
    begin
        offset_bits_next = offset_bits_reg;
        index_bits_next  = index_bits_reg;
        ways_next        = ways_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                salru_pkg::REG_OFFSET_BITS: offset_bits_next = cfg_data;
                salru_pkg::REG_INDEX_BITS:  index_bits_next  = cfg_data;
                salru_pkg::REG_WAYS_IN_USE: ways_next        = cfg_data;
                default:                    ways_next        = ways_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= salru_pkg::OFFSET_RESET;
            index_bits_reg  <= salru_pkg::INDEX_RESET;
            ways_reg        <= salru_pkg::WAYS_RESET;
        end
        else
        begin
            offset_bits_reg <= offset_bits_next;
            index_bits_reg  <= index_bits_next;
            ways_reg        <= ways_next;
        end
    end

    // Limit the geometry to its legal range
    always_comb
    begin
        priority if (offset_bits_reg < CW'(salru_pkg::OFFSET_MIN))
            cfg.offset_bits = CW'(salru_pkg::OFFSET_MIN);
        else if (offset_bits_reg > CW'(salru_pkg::OFFSET_MAX))
            cfg.offset_bits = CW'(salru_pkg::OFFSET_MAX);
        else
            cfg.offset_bits = offset_bits_reg;

        priority if (index_bits_reg > CW'(salru_pkg::INDEX_MAX))
            cfg.index_bits = CW'(salru_pkg::INDEX_MAX);
        else
            cfg.index_bits = index_bits_reg;

        priority if (ways_reg == '0)
            cfg.ways_in_use = CW'(1);
        else if ({1'b0, ways_reg} > (CW + 1)'(MAX_WAYS))
            cfg.ways_in_use = CW'(MAX_WAYS);
        else
            cfg.ways_in_use = ways_reg;
    end

    salru_front #(
        .MAX_SETS (MAX_SETS),
        .SET_W    (SET_W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .access_address (access_address),
        .cfg            (cfg),
        .back_status    (back_status),
        .q_count        (q_count),
        .busy           (busy),
        .push           (push),
        .push_tag       (push_tag),
        .push_set       (push_set)
    );

    salru_queue #(
        .SET_W (SET_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tag (push_tag),
        .push_set (push_set),
        .pop      (pop),
        .empty    (q_empty),
        .count    (q_count),
        .head_tag (head_tag),
        .head_set (head_set)
    );

    salru_back #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS),
        .SET_W    (SET_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_empty      (q_empty),
        .q_tag        (head_tag),
        .q_set        (head_set),
        .pop          (pop),
        .back_status  (back_status),
        .done         (done),
        .hit          (hit),
        .access_total (access_total),
        .miss_total   (miss_total)
    );

endmodule
